[hw/rtl/bf3_pkg.sv]
// Package for the 3x3 box mean filter: field widths, register indexes,
// the divide-by-nine constants and the stage and queue record types.
// No dependencies; every other file of the block uses it.
package bf3_pkg;

    // Field widths of the streams and registers.
    localparam int PIX_W     = 8;
    localparam int FW_W      = 12;
    localparam int FH_W      = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    // Width used to compare a column position against the frame width.
    localparam int CMP_W = 14;

    // A column sum holds three pixels, a window sum nine.
    localparam int COL_SUM_W = 10;
    localparam int WIN_SUM_W = 12;

    // Truncated divide by nine: floor(s * 7282 / 65536) equals s / 9 for s <= 2295.
    localparam int DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_PROD_W = WIN_SUM_W + DIV9_MUL_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd2048;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd1;

    // Result queue depth and pointer widths.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    // Control flags and pixel of an item on its way from the address stage to the window stage.
    typedef struct packed {
        logic            flush;
        logic            row0;
        logic            first;
        logic            last;
        logic            emit;
        logic            fwd;
        logic [PIX_W-1:0] px;
    } bf3_item_t;

    // One entry of the result queue; the mean is taken on the way out.
    typedef struct packed {
        logic [WIN_SUM_W-1:0] sum;
        logic                 eof;
        logic                 last_of_item;
    } bf3_result_t;

endpackage

[hw/rtl/bf3_if.sv]
// Stream and configuration interfaces of the 3x3 box mean filter.
// Depends on bf3_pkg for the field widths.

// Input pixel stream.
interface bf3_in_if;
    logic                     valid;
    logic                     ready;
    logic [bf3_pkg::PIX_W-1:0] pixel_in;
    logic                     is_flush;

    modport source (output valid, output pixel_in, output is_flush, input ready);
    modport sink   (input valid, input pixel_in, input is_flush, output ready);
endinterface

// Filtered pixel stream.
interface bf3_out_if;
    logic                     valid;
    logic                     ready;
    logic [bf3_pkg::PIX_W-1:0] pixel_out;
    logic                     end_of_frame;
    logic                     last_of_item;

    modport source (output valid, output pixel_out, output end_of_frame,
                    output last_of_item, input ready);
    modport sink   (input valid, input pixel_out, input end_of_frame,
                    input last_of_item, output ready);
endinterface

// Register write channel.
interface bf3_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bf3_pkg::CFG_IDX_W-1:0] index;
    logic [bf3_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/box_filter_3x3_replicate_unit.sv]
// Top level of the 3x3 box mean filter with replicated borders.
// Depends on bf3_pkg and the stream and configuration interfaces in bf3_if.sv.
//
// Throughput: one pixel transfer per cycle; the output drains one result per cycle
// while results.ready is high, and input ready drops only while the eight-entry result
// queue could overflow: more than four results held with an item in the window stage,
// or more than six without. Path: an item's row memory read is registered as it enters
// the window stage, whose update writes its results into the queue they are offered from.
// Reset: counters, window sums and queue clear at once; the row memory is not cleared.
module box_filter_3x3_replicate_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic      clk,
    input  logic      rst_n,
    bf3_cfg_if.sink   cfg,
    bf3_in_if.sink    pixels,
    bf3_out_if.source results
);
    import bf3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

    // Configuration registers.
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    // Frame position.
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [FH_W-1:0] row_reg;
    logic [FH_W-1:0] row_next;
    logic            flush_reg;
    logic            flush_next;

    // Window stage.
    logic              s1_valid_reg;
    bf3_item_t         s1_reg;
    bf3_item_t         s1_next;
    logic [CW-1:0]     s1_addr_reg;
    logic [PIX_W-1:0]  fwd_up_reg;
    logic [PIX_W-1:0]  fwd_mid_reg;
    logic [COL_SUM_W-1:0] col1_reg;
    logic [COL_SUM_W-1:0] col2_reg;

    // Row memory: upper row in the high byte, middle row in the low byte.
    logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    // Result queue.
    bf3_result_t      queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic in_xfer;
    logic out_xfer;

    // Combinational signals of the address stage.
    logic [CMP_W-1:0] w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [CMP_W-1:0] col_plus;
    logic             last;
    logic [FH_W-1:0]  row_inc;

    // Combinational signals of the window stage.
    logic [PIX_W-1:0]     up_px;
    logic [PIX_W-1:0]     mid_px;
    logic [PIX_W-1:0]     bot_px;
    logic [COL_SUM_W-1:0] vsum;
    logic [COL_SUM_W-1:0] win0;
    logic [COL_SUM_W-1:0] win1;
    logic                 mem_we;
    logic [PIX_W-1:0]     wr_up;
    logic                 push_a;
    logic                 push_b;
    bf3_result_t          res_a;
    bf3_result_t          res_b;
    logic [QPTR_W-1:0]    wr_b_ptr;
    logic [DIV9_PROD_W-1:0] mean_prod;
    logic [QCNT_W:0]      room_need;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg.data[FW_W-1:0];
            end
            else
            begin
                frame_height_reg <= cfg.data[FH_W-1:0];
            end
        end
    end

    // Input is taken while the queue has room for the results of both stages.
    assign room_need = {1'b0, count_reg} + (s1_valid_reg ? (QCNT_W+1)'(4) : (QCNT_W+1)'(2));
    assign pixels.ready = (room_need <= (QCNT_W+1)'(QUEUE_DEPTH));
    assign in_xfer  = pixels.valid && pixels.ready;
    assign out_xfer = results.valid && results.ready;

    // Effective frame size and the position of the next item.
    always_comb
    begin
        w_eff = (frame_width_reg == '0) ? CMP_W'(1) : CMP_W'(frame_width_reg);
        if (w_eff > MAX_W_C)
        begin
            w_eff = MAX_W_C;
        end
        h_eff    = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
        col_plus = CMP_W'(col_reg) + CMP_W'(1);
        last     = (col_plus >= w_eff);
        row_inc  = row_reg + FH_W'(1);

        col_next   = last ? '0 : col_plus[CW-1:0];
        row_next   = row_reg;
        flush_next = flush_reg;
        if (last)
        begin
            if (flush_reg)
            begin
                row_next   = '0;
                flush_next = 1'b0;
            end
            else
            begin
                row_next   = row_inc;
                flush_next = (row_inc >= h_eff) || (row_inc == '0);
            end
        end

        s1_next.flush = flush_reg;
        s1_next.row0  = (row_reg == '0);
        s1_next.first = (col_reg == '0);
        s1_next.last  = last;
        s1_next.emit  = flush_reg || (row_reg != '0);
        // The item one stage ahead writes the same entry this cycle.
        s1_next.fwd   = s1_valid_reg && !s1_reg.flush && (s1_addr_reg == col_reg);
        s1_next.px    = pixels.pixel_in;
    end

    // Position counters and the hand-off to the window stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            flush_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
            if (in_xfer)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                flush_reg <= flush_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_reg      <= s1_next;
            s1_addr_reg <= col_reg;
            fwd_up_reg  <= wr_up;
            fwd_mid_reg <= s1_reg.px;
        end
    end

    // Window stage: row pixels of this column, memory write-back and results.
    always_comb
    begin
        up_px  = s1_reg.fwd ? fwd_up_reg  : rd_data_reg[2*PIX_W-1:PIX_W];
        mid_px = s1_reg.fwd ? fwd_mid_reg : rd_data_reg[PIX_W-1:0];
        bot_px = s1_reg.flush ? mid_px : s1_reg.px;
        vsum   = COL_SUM_W'(up_px) + COL_SUM_W'(mid_px) + COL_SUM_W'(bot_px);

        // The first row stands in for the row above it as well.
        wr_up  = s1_reg.row0 ? s1_reg.px : mid_px;
        mem_we = s1_valid_reg && !s1_reg.flush;

        win0 = s1_reg.first ? vsum : col1_reg;
        win1 = s1_reg.first ? vsum : col2_reg;

        res_a.sum          = WIN_SUM_W'(win0) + WIN_SUM_W'(win1) + WIN_SUM_W'(vsum);
        res_a.eof          = 1'b0;
        res_a.last_of_item = !s1_reg.last;
        res_b.sum          = WIN_SUM_W'(win1) + WIN_SUM_W'(vsum) + WIN_SUM_W'(vsum);
        res_b.eof          = s1_reg.flush;
        res_b.last_of_item = 1'b1;

        push_a   = s1_valid_reg && s1_reg.emit && !s1_reg.first;
        push_b   = s1_valid_reg && s1_reg.emit && s1_reg.last;
        wr_b_ptr = push_a ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    end

    // Row memory, read every cycle at the current column, written from the window stage.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= row_mem[col_reg];
        if (mem_we)
        begin
            row_mem[s1_addr_reg] <= {wr_up, s1_reg.px};
        end
    end

    // Column sums of the window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col1_reg <= '0;
            col2_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            col1_reg <= win1;
            col2_reg <= vsum;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            queue_reg[wr_ptr_reg] <= res_a;
        end
        if (push_b)
        begin
            queue_reg[wr_b_ptr] <= res_b;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_a) + QPTR_W'(push_b);
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(out_xfer);
        end
    end

    // Output: the mean is the window sum times the reciprocal of nine.
    assign mean_prod = DIV9_PROD_W'(queue_reg[rd_ptr_reg].sum) * DIV9_PROD_W'(DIV9_MUL);
    assign results.valid        = (count_reg != '0);
    assign results.pixel_out    = mean_prod[DIV9_SHIFT+PIX_W-1:DIV9_SHIFT];
    assign results.end_of_frame = queue_reg[rd_ptr_reg].eof;
    assign results.last_of_item = queue_reg[rd_ptr_reg].last_of_item;

endmodule
